// ===== rtl/msbp_pkg.sv =====
// Package for the MSB-first bit packer: widths, field limits and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package msbp_pkg;

    localparam int FIELD_W        = 64;            // width of field_value
    localparam int LEN_W          = 7;             // width of field_length
    localparam int MAX_FIELD_BITS = 64;            // longer fields saturate here
    localparam int BYTE_W         = 8;
    localparam int OFF_W          = 3;             // bit offset inside a byte
    localparam int ACC_W          = FIELD_W + BYTE_W;
    localparam int CNT_W          = 4;             // 0..8 bytes per item
    localparam int IN_TDATA_W     = 72;            // value + length, padded to bytes

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // take the accepted item
        logic flush;    // offered item is a flush
        logic shift;    // current byte taken, move to the next
    } msbp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] nbytes;   // bytes the offered item would complete
    } msbp_status_t;

endpackage

`default_nettype wire

// ===== rtl/msbp_ctrl.sv =====
// Controller for the MSB-first bit packer: input handshake, byte counter
// and output valid/last. Depends on msbp_pkg.
`default_nettype none

module msbp_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       out_last,
    input  wire msbp_pkg::msbp_status_t status,
    input  wire logic                  is_flush,
    output msbp_pkg::msbp_cmd_t        cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                     state_reg, state_next;
    logic [msbp_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic in_acc;
    logic out_acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_last  = (cnt_reg == msbp_pkg::CNT_W'(1));
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;

    always_comb
    begin
        cmd.load   = in_acc;
        cmd.flush  = is_flush;
        cmd.shift  = out_acc;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && status.nbytes != '0)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = status.nbytes;
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    cnt_next = cnt_reg - msbp_pkg::CNT_W'(1);
                    if (out_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msbp_datapath.sv =====
// Datapath for the MSB-first bit packer: field alignment, merge with the
// pending bits, and the byte shift register. Depends on msbp_pkg.
`default_nettype none

module msbp_datapath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire msbp_pkg::msbp_cmd_t           cmd,
    input  wire logic [msbp_pkg::FIELD_W-1:0]  field_value,
    input  wire logic [msbp_pkg::LEN_W-1:0]    field_length,
    output msbp_pkg::msbp_status_t             status,
    output logic [msbp_pkg::BYTE_W-1:0]        out_byte
);

    // acc_reg top byte holds the pending bits (MSB aligned) when idle;
    // bits below the pending ones are always zero.
    logic [msbp_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [msbp_pkg::OFF_W-1:0] off_reg, off_next;

    logic [msbp_pkg::LEN_W-1:0]   len_sat;
    logic [msbp_pkg::LEN_W-1:0]   align_sh;
    logic [msbp_pkg::FIELD_W-1:0] field_left;
    logic [msbp_pkg::ACC_W-1:0]   merged;
    logic [msbp_pkg::LEN_W-1:0]   total;

    always_comb
    begin
        if (field_length > msbp_pkg::LEN_W'(msbp_pkg::MAX_FIELD_BITS))
            len_sat = msbp_pkg::LEN_W'(msbp_pkg::MAX_FIELD_BITS);
        else
            len_sat = field_length;
        // left-justify: shifting out the top drops the unused high bits
        align_sh   = msbp_pkg::LEN_W'(msbp_pkg::FIELD_W) - len_sat;
        field_left = field_value << align_sh;
        merged     = acc_reg | ({field_left, {msbp_pkg::BYTE_W{1'b0}}} >> off_reg);
        total      = msbp_pkg::LEN_W'(off_reg) + len_sat;
        if (cmd.flush)
            status.nbytes = (off_reg != '0) ? msbp_pkg::CNT_W'(1) : '0;
        else
            status.nbytes = total[msbp_pkg::LEN_W-1:msbp_pkg::OFF_W];
    end

    always_comb
    begin
        acc_next = acc_reg;
        off_next = off_reg;
        if (cmd.load)
        begin
            if (cmd.flush)
            begin
                off_next = '0;   // pending byte drains out through the shift
            end
            else
            begin
                acc_next = merged;
                off_next = total[msbp_pkg::OFF_W-1:0];
            end
        end
        else if (cmd.shift)
        begin
            acc_next = acc_reg << msbp_pkg::BYTE_W;
        end
    end

    assign out_byte = acc_reg[msbp_pkg::ACC_W-1 -: msbp_pkg::BYTE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            off_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            off_reg <= off_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msb_first_bit_packer.sv =====
// Top level of the MSB-first bit packer: stream ports, controller and
// datapath. Depends on msbp_pkg, msbp_ctrl and msbp_datapath.
//
//  Channel | Dir | Handshake          | tdata                         | side band
//  --------+-----+--------------------+-------------------------------+----------------
//  s_*     | in  | s_tvalid/s_tready  | [63:0] field_value,           | s_tuser[0]
//          |     |                    | [70:64] field_length, [71] 0  |  = req_type
//  m_*     | out | m_tvalid/m_tready  | [7:0] out_byte                | m_tlast
//          |     |                    |                               |  = last_of_run
//
// An item is taken on the s_* handshake; its bytes (0 to 8) then leave one per
// cycle while m_tready is high, so a push gives floor((offset + length) / 8) bytes.
// The byte shift register and the single byte-wide output port set the rate.
// A push or flush that completes no byte shows nothing.
// s_tready is low while bytes of the current item are being sent; output
// stalls simply hold the current byte. Reset clears the pending bits.
`default_nettype none

module msb_first_bit_packer
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [msbp_pkg::IN_TDATA_W-1:0]   s_tdata,   // field_value, field_length, pad
    input  wire logic [0:0]                        s_tuser,   // req_type
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [msbp_pkg::BYTE_W-1:0]            m_tdata,   // out_byte
    output logic                                   m_tlast    // last_of_run
);

    msbp_pkg::msbp_cmd_t    cmd;
    msbp_pkg::msbp_status_t status;

    logic [msbp_pkg::FIELD_W-1:0] field_value;
    logic [msbp_pkg::LEN_W-1:0]   field_length;
    logic                         is_flush;

    // unpack the input item; top pad bit is ignored
    assign field_value  = s_tdata[msbp_pkg::FIELD_W-1:0];
    assign field_length = s_tdata[msbp_pkg::FIELD_W +: msbp_pkg::LEN_W];
    assign is_flush     = (s_tuser[0] == msbp_pkg::REQ_FLUSH);

    msbp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .status    (status),
        .is_flush  (is_flush),
        .cmd       (cmd)
    );

    msbp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .field_value  (field_value),
        .field_length (field_length),
        .status       (status),
        .out_byte     (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/msbp_checker.sv =====
// Port-level checks for msb_first_bit_packer, attached by bind.
// Depends on msbp_pkg and the top level's ports.
`default_nettype none

module msbp_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [msbp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic [0:0]                        s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [msbp_pkg::BYTE_W-1:0]       m_tdata,
    input  wire logic                              m_tlast
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // one item in flight: no input taken while bytes are being shown
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // stalled output byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed under stall");

    // bytes of one item leave without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an item's bytes");

    // a flush gives at most one byte
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_tuser[0] == msbp_pkg::REQ_FLUSH) |=> !m_tvalid || m_tlast)
        else $error("flush produced more than one byte");

    // an empty push gives nothing
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_tuser[0] == msbp_pkg::REQ_PUSH)
        && (s_tdata[msbp_pkg::FIELD_W +: msbp_pkg::LEN_W] == '0) |=> !m_tvalid)
        else $error("zero-length push produced output");

endmodule

bind msb_first_bit_packer msbp_checker u_msbp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for msb_first_bit_packer: random and directed push/flush
// items against a bit-level prediction of the packed byte stream.
// Depends on rtl/msbp_pkg.sv and rtl/msb_first_bit_packer.sv.

typedef struct packed {
    logic [7:0] data;
    logic       last;
} packed_byte_t;

// Tracks the pending partial byte and the bytes each item must produce.
class packed_stream_model;
    logic [7:0]   partial_bits;
    int unsigned  pending_bits;
    packed_byte_t bytes_due[$];
    int unsigned  errors;

    function new();
        partial_bits = '0;
        pending_bits = 0;
        errors       = 0;
    endfunction

    function void take_item(logic req, logic [63:0] value, logic [6:0] length);
        int unsigned  nbits;
        int unsigned  nbytes;
        int unsigned  emitted;
        packed_byte_t b;
        emitted = 0;
        if (req == msbp_pkg::REQ_FLUSH) begin
            if (pending_bits != 0) begin
                b.data = partial_bits;
                b.last = 1'b1;
                bytes_due = {bytes_due, b};
            end
            partial_bits = '0;
            pending_bits = 0;
            return;
        end
        nbits  = (length > msbp_pkg::MAX_FIELD_BITS) ? msbp_pkg::MAX_FIELD_BITS : length;
        nbytes = (pending_bits + nbits) / 8;
        // only bits below nbits are read, which masks the value
        for (int i = int'(nbits) - 1; i >= 0; i--) begin
            partial_bits[7 - pending_bits] = value[i];
            pending_bits++;
            if (pending_bits == 8) begin
                emitted++;
                b.data = partial_bits;
                b.last = (emitted == nbytes);
                bytes_due = {bytes_due, b};
                partial_bits = '0;
                pending_bits = 0;
            end
        end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
        packed_byte_t b;
        if (bytes_due.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual data %02h last %0b",
                     $time, data, last);
            errors++;
            return;
        end
        b = bytes_due.pop_front();
        if (b.data !== data) begin
            $display("%0t: out_byte mismatch, expected %02h actual %02h",
                     $time, b.data, data);
            errors++;
        end
        if (b.last !== last) begin
            $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                     $time, b.last, last);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return bytes_due.size();
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous: the ~120 items, even with sink stalls, finish well inside this
    // limit; it only catches a hang.
    localparam int CYCLE_LIMIT = 100000;
    // Drain time after the last expected byte.
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_PER_PHASE = 32;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [msbp_pkg::IN_TDATA_W-1:0] s_tdata  = '0;   // field_value, field_length, pad
    logic [0:0]                      s_tuser  = '0;   // req_type
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [msbp_pkg::BYTE_W-1:0]     m_tdata;         // out_byte
    logic                            m_tlast;         // last_of_run

    packed_stream_model model = new();

    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned cycle_count   = 0;

    msb_first_bit_packer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hang guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Output side: check on handshake (values sampled before this edge's
    // updates), then pick next cycle's tready.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            model.check_byte(m_tdata, m_tlast);
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Offer one item and hold it until accepted. Each idle cycle is drawn
    // separately, so tvalid never toggles twice in one step.
    task automatic offer_item(input logic req, input logic [63:0] value,
                              input logic [6:0] length);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(msbp_pkg::IN_TDATA_W - msbp_pkg::FIELD_W - msbp_pkg::LEN_W){1'b0}},
                     length, value};
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        model.take_item(req, value, length);
    endtask

    // Random item: mostly pushes, lengths mostly in range, some saturating.
    task automatic offer_random_item();
        logic        req;
        logic [63:0] value;
        logic [6:0]  length;
        int unsigned pick;
        req   = ($urandom_range(0, 99) < 15) ? msbp_pkg::REQ_FLUSH : msbp_pkg::REQ_PUSH;
        value = {$urandom, $urandom};
        pick  = $urandom_range(0, 99);
        if (pick < 5)
            value = '1;
        else if (pick < 10)
            value = '0;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            length = 7'($urandom_range(msbp_pkg::MAX_FIELD_BITS + 1, 127));
        else if (pick < 20)
            length = 7'(msbp_pkg::MAX_FIELD_BITS);
        else
            length = 7'($urandom_range(0, msbp_pkg::MAX_FIELD_BITS - 1));
        offer_item(req, value, length);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs under the first idling mix.
        src_idle_pct  = 34;
        sink_idle_pct = 49;

        offer_item(msbp_pkg::REQ_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);   // nothing pending
        offer_item(msbp_pkg::REQ_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd0);    // zero length
        offer_item(msbp_pkg::REQ_PUSH,  64'h0000_0000_0000_00A5, 7'd8);    // exact byte
        offer_item(msbp_pkg::REQ_PUSH,  64'h0000_0000_0000_0005, 7'd3);
        offer_item(msbp_pkg::REQ_PUSH,  64'h0000_0000_0000_0013, 7'd5);    // across items
        offer_item(msbp_pkg::REQ_PUSH,  64'h0000_0000_0000_0001, 7'd1);
        offer_item(msbp_pkg::REQ_FLUSH, 64'h0,                   7'd0);    // one pending bit
        offer_item(msbp_pkg::REQ_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64);   // eight, aligned
        offer_item(msbp_pkg::REQ_PUSH,  64'h0000_0000_0000_0003, 7'd3);
        offer_item(msbp_pkg::REQ_PUSH,  64'h0123_4567_89AB_CDEF, 7'd64);   // eight, misaligned
        offer_item(msbp_pkg::REQ_FLUSH, 64'h0,                   7'd0);
        offer_item(msbp_pkg::REQ_PUSH,  64'hDEAD_BEEF_CAFE_F00D, 7'd127);  // saturates
        offer_item(msbp_pkg::REQ_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd65);   // just above max
        offer_item(msbp_pkg::REQ_PUSH,  64'hFFFF_FFFF_FFFF_FFF0, 7'd4);    // upper bits masked
        offer_item(msbp_pkg::REQ_FLUSH, 64'h0,                   7'd0);    // zero bits
        offer_item(msbp_pkg::REQ_PUSH,  64'h0000_0000_0000_007F, 7'd7);
        offer_item(msbp_pkg::REQ_FLUSH, 64'h0,                   7'd0);    // seven pending
        offer_item(msbp_pkg::REQ_PUSH,  64'h0,                   7'd64);
        offer_item(msbp_pkg::REQ_PUSH,  64'h5555_5555_5555_5555, 7'd63);
        offer_item(msbp_pkg::REQ_PUSH,  64'h0000_0000_0000_0001, 7'd1);    // exact byte
        offer_item(msbp_pkg::REQ_PUSH,  64'h0000_0000_0000_0002, 7'd2);
        offer_item(msbp_pkg::REQ_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd0);    // zero, bits pending
        offer_item(msbp_pkg::REQ_FLUSH, 64'h8000_0000_0000_0000, 7'd100);
        offer_item(msbp_pkg::REQ_FLUSH, 64'h0,                   7'd0);    // back-to-back

        // Random part in three idling mixes.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 34; sink_idle_pct = 49; end
                1:       begin src_idle_pct = 49; sink_idle_pct = 34; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            repeat (RANDOM_PER_PHASE) offer_random_item();
        end
        s_tvalid <= 1'b0;

        while (model.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (model.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/msbp_pkg.sv
rtl/msbp_ctrl.sv
rtl/msbp_datapath.sv
rtl/msb_first_bit_packer.sv
rtl/msbp_checker.sv
bench/tb_top.sv
